// ===== src/dsp_pkg.sv =====
// Shared constants, types and state codes of the shortest path engine.
`default_nettype none
package dsp_pkg;

	localparam int MAX_V  = 32;
	localparam int V_W    = $clog2(MAX_V);
	localparam int CNT_W  = V_W + 1;
	localparam int ADDR_W = 2 * V_W;
	localparam int W_W    = 16;
	localparam int DIST_W = 21;

	localparam logic [W_W-1:0]    NO_EDGE  = {W_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [CNT_W-1:0]  VC_RESET = CNT_W'(MAX_V);

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_EDGE  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic REG_VCOUNT = 1'b0;
	localparam logic REG_UNDIR  = 1'b1;

	// Byte addresses of the registers on the configuration port.
	localparam logic [2:0] ADDR_VCOUNT = 3'd0;
	localparam logic [2:0] ADDR_UNDIR  = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MIRROR,
		ST_RELAX,
		ST_SELECT,
		ST_WAIT,
		ST_OUT
	} state_t;

	// Token handed from cell to cell: a relax op or a minimum search.
	typedef struct packed {
		logic              valid;
		logic              sel;
		logic [V_W-1:0]    col;
		logic [W_W-1:0]    weight;
		logic [DIST_W-1:0] base;
		logic [V_W-1:0]    src;
		logic              found;
		logic [DIST_W-1:0] best;
		logic [V_W-1:0]    bidx;
	} tok_t;

	typedef struct packed {
		logic             init;
		logic [CNT_W-1:0] n;
		logic [V_W-1:0]   src;
		logic             src_ok;
		logic             fin_set;
		logic [V_W-1:0]   fin_idx;
	} ctl_t;

	typedef struct packed {
		logic              known;
		logic [DIST_W-1:0] path_len;
		logic [V_W-1:0]    prev;
	} stat_t;

endpackage
`default_nettype wire

// ===== src/dsp_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface dsp_in_if import dsp_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [1:0]     kind;
	logic [V_W-1:0] from_vertex;
	logic [V_W-1:0] to_vertex;
	logic [W_W-1:0] weight;
	modport source (output valid, kind, from_vertex, to_vertex, weight, input ready);
	modport sink (input valid, kind, from_vertex, to_vertex, weight, output ready);
endinterface

interface dsp_out_if import dsp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [V_W-1:0]    vertex;
	logic [DIST_W-1:0] distance;
	logic              reachable;
	logic [V_W-1:0]    predecessor;
	logic              last;
	modport source (output valid, vertex, distance, reachable, predecessor, last,
		input ready);
	modport sink (input valid, vertex, distance, reachable, predecessor, last,
		output ready);
endinterface
`default_nettype wire

// ===== src/dijkstra_shortest_paths.sv =====
// Top level: matrix store, sequencer and the chain of vertex cells.
// Edge write: written as it is accepted, the mirrored write following in
// ST_MIRROR; a clear walks all 1024 matrix entries. A query relaxes each
// settled vertex's row, one matrix entry read per cycle, then passes a search
// token through the 32-cell chain; then n results, one per cycle when taken.
// Reset: a clearing pass writes no-edge to all 1024 matrix entries; no
// input transaction is accepted until it ends. Configuration resets to 32, 0.
`default_nettype none
module dijkstra_shortest_paths import dsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dsp_in_if.sink           in_ch,
	dsp_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  vcount_q, n_act, n_q;
	logic              undir_q;
	logic [ADDR_W-1:0] clr_q;
	logic [V_W-1:0]    mir_a_q, mir_b_q, k_q, j_q, oi_q;
	logic [W_W-1:0]    mir_w_q;
	logic [DIST_W-1:0] dk_q;
	logic              iss_v_s1, iss_sel_s1;
	logic [V_W-1:0]    iss_col_s1;
	logic              in_acc, out_acc, src_ok, j_last, o_last, exit_sel;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [W_W-1:0]    wdata, rdata;
	logic              iss_v, iss_sel;
	ctl_t              ctl;
	tok_t              tok [MAX_V+1];
	stat_t             stat [MAX_V];
	stat_t             cur;

	// Configuration port: always ready, register index in paddr[2].
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_UNDIR) ? {31'b0, undir_q} : {{(32-CNT_W){1'b0}}, vcount_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VC_RESET;
			undir_q  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_VCOUNT) begin
				vcount_q <= pwdata[CNT_W-1:0];
			end else begin
				undir_q <= pwdata[0];
			end
		end
	end

	// Active vertex count: zero acts as one, saturate at the cell count.
	always_comb begin
		n_act = vcount_q;
		if (vcount_q == '0) begin
			n_act = CNT_W'(1);
		end else if (vcount_q > CNT_W'(MAX_V)) begin
			n_act = CNT_W'(MAX_V);
		end
	end

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_acc  = out_ch.valid && out_ch.ready;
	assign src_ok   = CNT_W'(in_ch.from_vertex) < n_act;
	assign j_last   = CNT_W'(j_q) == n_q - CNT_W'(1);
	assign o_last   = CNT_W'(oi_q) == n_q - CNT_W'(1);
	assign exit_sel = tok[MAX_V].valid && tok[MAX_V].sel;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == {ADDR_W{1'b1}}) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					priority case (in_ch.kind)
						KIND_CLEAR: state_d = ST_CLEAR;
						KIND_EDGE:  state_d = undir_q ? ST_MIRROR : ST_IDLE;
						KIND_QUERY: state_d = src_ok ? ST_RELAX : ST_OUT;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_MIRROR: state_d = ST_IDLE;
			ST_RELAX: begin
				if (j_last) state_d = ST_SELECT;
			end
			ST_SELECT: state_d = ST_WAIT;
			ST_WAIT: begin
				if (exit_sel) state_d = tok[MAX_V].found ? ST_RELAX : ST_OUT;
			end
			ST_OUT: begin
				if (out_acc && o_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		we           = 1'b0;
		waddr        = {in_ch.from_vertex, in_ch.to_vertex};
		wdata        = in_ch.weight;
		raddr        = {k_q, j_q};
		iss_v        = 1'b0;
		iss_sel      = 1'b0;
		in_ch.ready  = 1'b0;
		out_ch.valid = 1'b0;
		ctl.init     = 1'b0;
		ctl.n        = n_act;
		ctl.src      = in_ch.from_vertex;
		ctl.src_ok   = src_ok;
		ctl.fin_set  = 1'b0;
		ctl.fin_idx  = tok[MAX_V].bidx;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = NO_EDGE;
			end
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				we          = in_ch.valid && in_ch.kind == KIND_EDGE;
				ctl.init    = in_ch.valid && in_ch.kind == KIND_QUERY;
			end
			ST_MIRROR: begin
				we    = 1'b1;
				waddr = {mir_b_q, mir_a_q};
				wdata = mir_w_q;
			end
			ST_RELAX:  iss_v = 1'b1;
			ST_SELECT: iss_sel = 1'b1;
			ST_WAIT:   ctl.fin_set = exit_sel && tok[MAX_V].found;
			ST_OUT:    out_ch.valid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			iss_v_s1   <= 1'b0;
			iss_sel_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			iss_v_s1   <= iss_v;
			iss_sel_s1 <= iss_sel;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		iss_col_s1 <= j_q;
		if (state_q == ST_IDLE && in_acc) begin
			mir_a_q <= in_ch.from_vertex;
			mir_b_q <= in_ch.to_vertex;
			mir_w_q <= in_ch.weight;
			n_q     <= n_act;
			k_q     <= in_ch.from_vertex;
			dk_q    <= '0;
			j_q     <= '0;
			oi_q    <= '0;
		end
		if (state_q == ST_RELAX) begin
			j_q <= j_q + V_W'(1);
		end
		if (state_q == ST_WAIT && exit_sel) begin
			k_q  <= tok[MAX_V].bidx;
			dk_q <= tok[MAX_V].best;
			j_q  <= '0;
		end
		if (state_q == ST_OUT && out_acc) begin
			oi_q <= oi_q + V_W'(1);
		end
	end

	dsp_matrix u_matrix (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Inject a relax token per row entry, then one search token behind them.
	always_comb begin
		tok[0]        = '0;
		tok[0].valid  = iss_v_s1 || iss_sel_s1;
		tok[0].sel    = !iss_v_s1;
		tok[0].col    = iss_col_s1;
		tok[0].weight = rdata;
		tok[0].base   = dk_q;
		tok[0].src    = k_q;
	end

	for (genvar i = 0; i < MAX_V; i++) begin : g_cell
		dsp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (V_W'(i)),
			.ctl    (ctl),
			.tok_i  (tok[i]),
			.tok_q  (tok[i+1]),
			.stat   (stat[i])
		);
	end

	// Results: walk the cells in index order; unreachable reads as zero.
	assign cur                = stat[oi_q];
	assign out_ch.vertex      = oi_q;
	assign out_ch.reachable   = cur.known;
	assign out_ch.distance    = cur.known ? cur.path_len : '0;
	assign out_ch.predecessor = cur.known ? cur.prev : '0;
	assign out_ch.last        = o_last;
endmodule
`default_nettype wire

// ===== src/dsp_matrix.sv =====
// Adjacency matrix store: one write port, one registered read port.
`default_nettype none
module dsp_matrix import dsp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [W_W-1:0]    wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [W_W-1:0]    rdata
);
	logic [W_W-1:0] mem [MAX_V*MAX_V];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/dsp_cell.sv =====
// One vertex cell: holds its distance state, relaxes and joins the minimum search.
`default_nettype none
module dsp_cell import dsp_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [V_W-1:0] idx,
	input  wire ctl_t           ctl,
	input  wire tok_t           tok_i,
	output tok_t                tok_q,
	output stat_t               stat
);
	logic              active_q, fin_q, known_q;
	logic [DIST_W-1:0] dist_q;
	logic [V_W-1:0]    prev_q;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] cand;
	logic              upd, take;
	tok_t              tok_d;

	always_comb begin
		sum  = {1'b0, tok_i.base} + (DIST_W+1)'(tok_i.weight);
		cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
		upd  = tok_i.valid && !tok_i.sel && tok_i.col == idx && active_q && !fin_q
			&& tok_i.weight != NO_EDGE && (!known_q || cand < dist_q);
		take = tok_i.valid && tok_i.sel && active_q && !fin_q && known_q
			&& (!tok_i.found || dist_q < tok_i.best);
		tok_d = tok_i;
		if (take) begin
			tok_d.found = 1'b1;
			tok_d.best  = dist_q;
			tok_d.bidx  = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			fin_q    <= 1'b0;
			known_q  <= 1'b0;
			tok_q    <= '0;
		end else begin
			tok_q <= tok_d;
			if (ctl.init) begin
				active_q <= CNT_W'(idx) < ctl.n;
				fin_q    <= ctl.src_ok && idx == ctl.src;
				known_q  <= ctl.src_ok && idx == ctl.src;
			end else begin
				if (ctl.fin_set && ctl.fin_idx == idx) begin
					fin_q <= 1'b1;
				end
				if (upd) begin
					known_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			dist_q <= '0;
			prev_q <= ctl.src;
		end else if (upd) begin
			dist_q <= cand;
			prev_q <= tok_i.src;
		end
	end

	assign stat = '{known: known_q, path_len: dist_q, prev: prev_q};
endmodule
`default_nettype wire

// ===== tb/dsp_path_checker.sv =====
// Path checker: rebuilds the edge matrix, predicts every query's results and compares them.
`timescale 1ns / 1ps
module dsp_path_checker import dsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dsp_in_if                in_ch,
	dsp_out_if               out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               fails,
	output int               pending,
	output int               items_seen,
	output int               results_seen,
	output int               queries_seen
);

	typedef struct {
		logic [V_W-1:0]    vertex;
		logic [DIST_W-1:0] distance;
		logic              reachable;
		logic [V_W-1:0]    predecessor;
		logic              last;
	} vertex_result_t;

	logic [W_W-1:0]   weights [MAX_V][MAX_V];
	logic [CNT_W-1:0] vcount;
	logic             undirected;
	vertex_result_t   path_results [$];

	task automatic report(input string what, input int unsigned want, input int unsigned got);
		$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		fails++;
	endtask

	function automatic int unsigned sat_sum(input int unsigned a, input int unsigned b);
		longint unsigned s;
		s = longint'(a) + longint'(b);
		return (s > DIST_MAX) ? DIST_MAX : int'(s);
	endfunction

	// Run the search from src and queue one result per active vertex.
	task automatic predict_paths(input logic [V_W-1:0] src);
		int n, k;
		bit found;
		int unsigned best, cand;
		bit done [MAX_V];
		bit known [MAX_V];
		int unsigned path_len [MAX_V];
		logic [V_W-1:0] prv [MAX_V];
		vertex_result_t r;
		n = (vcount == 0) ? 1 : (vcount > MAX_V) ? MAX_V : int'(vcount);
		for (int i = 0; i < MAX_V; i++) begin
			done[i] = 0; known[i] = 0; path_len[i] = 0; prv[i] = '0;
		end
		if (src < n) begin
			for (int i = 0; i < n; i++)
				if (weights[src][i] != NO_EDGE) begin
					known[i] = 1;
					path_len[i] = weights[src][i];
					prv[i] = src;
				end
			known[src] = 1; path_len[src] = 0; prv[src] = src; done[src] = 1;
			forever begin
				found = 0; best = 0; k = 0;
				for (int j = 0; j < n; j++)
					if (!done[j] && known[j] && (!found || path_len[j] < best)) begin
						found = 1; best = path_len[j]; k = j;
					end
				if (!found)
					break;
				done[k] = 1;
				for (int j = 0; j < n; j++)
					if (!done[j] && weights[k][j] != NO_EDGE) begin
						cand = sat_sum(path_len[k], weights[k][j]);
						if (!known[j] || cand < path_len[j]) begin
							known[j] = 1; path_len[j] = cand; prv[j] = V_W'(k);
						end
					end
			end
		end
		for (int i = 0; i < n; i++) begin
			r.vertex      = V_W'(i);
			r.distance    = known[i] ? DIST_W'(path_len[i]) : '0;
			r.reachable   = known[i];
			r.predecessor = known[i] ? prv[i] : '0;
			r.last        = (i == n - 1);
			path_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vertex_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < MAX_V; i++)
				for (int j = 0; j < MAX_V; j++)
					weights[i][j] = NO_EDGE;
			vcount = VC_RESET;
			undirected = 0;
			path_results.delete();
			fails = 0; items_seen = 0; results_seen = 0; queries_seen = 0;
		end else begin
			// register writes land at the access phase
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_VCOUNT)
					vcount = pwdata[CNT_W-1:0];
				else if (paddr == ADDR_UNDIR)
					undirected = pwdata[0];
			end
			if (in_ch.valid && in_ch.ready) begin
				items_seen++;
				case (in_ch.kind)
					KIND_CLEAR: begin
						for (int i = 0; i < MAX_V; i++)
							for (int j = 0; j < MAX_V; j++)
								weights[i][j] = NO_EDGE;
					end
					KIND_EDGE: begin
						weights[in_ch.from_vertex][in_ch.to_vertex] = in_ch.weight;
						if (undirected)
							weights[in_ch.to_vertex][in_ch.from_vertex] = in_ch.weight;
					end
					KIND_QUERY: begin
						queries_seen++;
						predict_paths(in_ch.from_vertex);
					end
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (path_results.size() == 0) begin
					$display("%0t unexpected result for vertex %0d", $realtime, out_ch.vertex);
					fails++;
				end else begin
					e = path_results.pop_front();
					if (out_ch.vertex !== e.vertex)
						report("vertex", e.vertex, out_ch.vertex);
					if (out_ch.distance !== e.distance)
						report("distance", e.distance, out_ch.distance);
					if (out_ch.reachable !== e.reachable)
						report("reachable", e.reachable, out_ch.reachable);
					if (out_ch.predecessor !== e.predecessor)
						report("predecessor", e.predecessor, out_ch.predecessor);
					if (out_ch.last !== e.last)
						report("last", e.last, out_ch.last);
				end
			end
		end
		pending = path_results.size();
	end

endmodule

// ===== tb/dijkstra_shortest_paths_test.sv =====
// Testbench top: drives edge, clear, query and unused-kind transactions and register writes, and gives the verdict.
`timescale 1ns / 1ps
module dijkstra_shortest_paths_test;
	import dsp_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// Longest quiet stretch: a full 32-vertex query, a clear, the long receiver hold
	// and the idle wait before register writes.
	localparam int QUIET_LIMIT = 30000;
	localparam int SETTLE      = 1200;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fails, pending, items_seen, results_seen, queries_seen;
	int          hold_request = 0;
	int          active_n = 32;
	int unsigned phase_vc [7] = '{32, 0, 63, 1, 7, 16, 3};

	dsp_in_if  in_ch ();
	dsp_out_if out_ch ();

	always #2 clk = ~clk;

	dijkstra_shortest_paths dut (
		.clk, .arst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	dsp_path_checker chk (
		.clk, .arst_n, .in_ch, .out_ch,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fails, .pending, .items_seen, .results_seen, .queries_seen
	);

	initial begin
		in_ch.valid = 0;
		in_ch.kind = KIND_CLEAR;
		in_ch.from_vertex = '0;
		in_ch.to_vertex = '0;
		in_ch.weight = '0;
		out_ch.ready = 0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Receiver: random stalls, plus a long hold whenever the stimulus asks.
	always @(posedge clk) begin
		int gap;
		if (hold_request > 0) begin
			out_ch.ready <= 0;
			hold_request <= hold_request - 1;
		end else if (gap > 0) begin
			out_ch.ready <= 0;
			gap--;
		end else begin
			out_ch.ready <= 1;
			gap = pick_gap();
		end
	end

	// Watchdog: give up when nothing moves for too long.
	always @(posedge clk) begin
		int quiet;
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet = 0;
		else if (++quiet >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet);
			$display("dijkstra_shortest_paths verification failed");
			$finish;
		end
	end

	// Offer one transaction, hold it until taken, then maybe drop valid for a gap.
	task automatic send(input logic [1:0] kind, input logic [V_W-1:0] a,
			input logic [V_W-1:0] b, input logic [W_W-1:0] w, input bit burst = 0);
		int gap;
		in_ch.valid <= 1;
		in_ch.kind <= kind;
		in_ch.from_vertex <= a;
		in_ch.to_vertex <= b;
		in_ch.weight <= w;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every expected result, then, if settle is set, let a clear finish.
	task automatic drain(input bit settle);
		in_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		if (settle)
			repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [5:0] vc, input bit undir);
		drain(1);
		// random upper bits must be ignored
		reg_write(ADDR_VCOUNT, {26'($urandom_range(32'h3ff_ffff)), vc});
		reg_write(ADDR_UNDIR, {31'($urandom_range(32'h7fff_ffff)), undir});
		active_n = (vc == 0) ? 1 : (vc > MAX_V) ? MAX_V : vc;
	endtask

	// Weight mix: mostly small so paths compete, some extremes and no-edge.
	function automatic logic [W_W-1:0] pick_weight();
		int r;
		r = $urandom_range(99);
		if (r < 60) return W_W'($urandom_range(20));
		if (r < 80) return W_W'($urandom());
		if (r < 88) return NO_EDGE;
		if (r < 94) return NO_EDGE - W_W'(1);
		return '0;
	endfunction

	function automatic logic [V_W-1:0] pick_vertex();
		if ($urandom_range(9) == 0) return V_W'($urandom());
		return V_W'($urandom_range(active_n - 1));
	endfunction

	// Sequence: optional clear, a batch of edges, queries, then now and then an unused kind.
	task automatic random_graph(input int edges, input int queries, input bit burst = 0);
		if ($urandom_range(3) == 0)
			send(KIND_CLEAR, V_W'($urandom()), V_W'($urandom()), W_W'($urandom()), burst);
		repeat (edges)
			send(KIND_EDGE, pick_vertex(), pick_vertex(), pick_weight(), burst);
		repeat (queries)
			send(KIND_QUERY, pick_vertex(), V_W'($urandom()), W_W'($urandom()), burst);
		if ($urandom_range(7) == 0)
			send(KIND_UNUSED, V_W'($urandom()), V_W'($urandom()), W_W'($urandom()), burst);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// Directed: extremes on the full graph, then a chain of heaviest edges.
		configure(6'd32, 0);
		send(KIND_QUERY, 5'd0, 5'd0, 16'd0);
		send(KIND_EDGE, 5'd0, 5'd31, 16'd0);
		send(KIND_EDGE, 5'd31, 5'd30, NO_EDGE - W_W'(1));
		send(KIND_EDGE, 5'd0, 5'd1, NO_EDGE);
		send(KIND_EDGE, 5'd31, 5'd31, 16'd5);
		send(KIND_UNUSED, 5'd31, 5'd31, 16'hffff);
		send(KIND_QUERY, 5'd0, 5'd31, 16'hffff);
		send(KIND_QUERY, 5'd31, 5'd0, 16'd0);
		for (int i = 0; i < 8; i++)
			send(KIND_EDGE, V_W'(i), V_W'(i + 1), NO_EDGE - W_W'(1));
		send(KIND_EDGE, 5'd0, 5'd8, 16'd100);
		send(KIND_EDGE, 5'd0, 5'd2, 16'd3);
		send(KIND_EDGE, 5'd1, 5'd2, 16'd3);
		send(KIND_QUERY, 5'd0, 5'd0, 16'd0);
		send(KIND_CLEAR, 5'd0, 5'd0, 16'd0);
		send(KIND_QUERY, 5'd8, 5'd0, 16'd0);

		// Mirrored writes and a source beyond the active vertices.
		configure(6'd4, 1);
		send(KIND_EDGE, 5'd1, 5'd3, 16'd7);
		send(KIND_EDGE, 5'd30, 5'd2, 16'd9);
		send(KIND_QUERY, 5'd3, 5'd0, 16'd0);
		send(KIND_QUERY, 5'd9, 5'd0, 16'd0);

		for (int p = 0; p < 7; p++) begin
			configure(6'(phase_vc[p]), p[0]);
			repeat (2)
				random_graph($urandom_range(26, 12), $urandom_range(3, 1));
			if (p == 3) begin
				// Long receiver hold while queries keep coming in back to back.
				hold_request = 400;
				random_graph(4, 5, 1);
			end
			if (p == 5) begin
				// Sender pauses until every result is back, then resumes.
				drain(0);
				random_graph(10, 2);
			end
		end
		configure(6'($urandom_range(32, 1)), 1'($urandom_range(1)));
		random_graph(15, 3);

		drain(0);
		repeat (200) @(posedge clk);
		$display("covered %0d transactions, %0d queries, %0d vertex results",
			items_seen, queries_seen, results_seen);
		$display("vertex counts 0 to 63 incl. saturation, both edge modes, clears and unused kind");
		if (fails == 0)
			$display("dijkstra_shortest_paths verification clean");
		else
			$display("dijkstra_shortest_paths verification failed");
		$finish;
	end

endmodule
